### sv/modular_arith_unit_assert.svh
// Assertion macros for the modular arithmetic unit.
`ifndef MODULAR_ARITH_UNIT_ASSERT_SVH
`define MODULAR_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MAU_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`else
`define MAU_ASSERT_IMPL(label, clk, rst, prop)
`endif
`ifndef SYNTHESIS
`define MAU_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MAU_ASSERT_NORST(label, clk, prop)
`endif
`endif

### sv/mau_pkg.sv
// Package with the shared types and constants of the modular arithmetic unit.
package mau_pkg;
   localparam int ResBits = 31;
   localparam logic [ResBits-1:0] ModulusReset = 31'd1000000007;
   // Multiplier bits scanned by one modular multiplication pass.
   localparam int PassSteps = 31;
   typedef enum logic [1:0] {
      CMD_POW = 2'd0,
      CMD_MUL = 2'd1,
      CMD_DIV = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;
   // Datapath operations issued by the controller; it sets at most one at a time.
   typedef struct packed {
      logic red_step;   // shift one operand bit into each reducer
      logic load_pow;   // x := reduced a, acc := 1
      logic load_inv;   // x := reduced b, acc := 1, exponent := p - 2
      logic load_mul;   // x := reduced b, acc := reduced a
      logic load_fin;   // x := reduced a, acc keeps the inverse
      logic pass_start; // clear both partial products, latch x as multiplier
      logic pass_step;  // one multiplier bit for both products
      logic pow_end;    // x := x*x, acc := acc*x when the exponent bit is set
      logic mul_end;    // acc := acc*x
   } dp_cmd_type;
   typedef struct packed {
      logic e_zero; // no exponent bits left
      logic b_zero; // reduced b is zero
   } dp_stat_type;
endpackage

### sv/mau_if.sv
// Valid/ready channel interfaces of the modular arithmetic unit.
interface mau_req_if #(parameter int OPERAND_BITS = 63);
   logic valid;
   logic ready;
   logic [1:0] command;
   logic [OPERAND_BITS-1:0] operand_a;
   logic [OPERAND_BITS-1:0] operand_b;
   modport source (output valid, command, operand_a, operand_b, input ready);
   modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if;
   logic valid;
   logic ready;
   logic [30:0] result;
   logic error;
   modport source (output valid, result, error, input ready);
   modport sink (input valid, result, error, output ready);
endinterface

### sv/modular_arith_unit.sv
// Top level of the modular arithmetic unit: controller, datapath, result register.
// The unit takes one item at a time and answers each with one residue modulo the
// csr_ modulus register (reset 1000000007). Both operands are first reduced together
// by two restoring reducers, one operand bit per cycle. Every modular product then
// comes from a pass of 31 multiplier bits with a doubling and an addition per bit,
// and power runs the square and the product in two such multipliers side by side,
// once for each exponent bit up to the highest set one. Multiply runs one such
// product; divide raises reduced b to the power modulus - 2 and multiplies the
// result by reduced a. A modulus below two and the unused command go straight to
// the done state with a zero result. req_ready is high whenever the controller
// idles, so the next item can start while a finished item waits in the result
// register for rsp_ready; a second finished item is held in the controller until
// that register is free.
`include "modular_arith_unit_assert.svh"
module modular_arith_unit #(
   parameter int OPERAND_BITS = 63
) (
   input  logic clock,
   input  logic reset,
   mau_req_if.sink   req,
   mau_rsp_if.source rsp,
   input  logic        csr_write,
   input  logic [30:0] csr_wdata
);
   logic [30:0] mod_ff;
   logic busy, done, err, zero;
   logic [30:0] acc;
   logic rv_ff;
   logic [30:0] res_ff;
   logic er_ff;
   mau_pkg::dp_cmd_type cmd;
   mau_pkg::dp_stat_type stat;
   logic start;
   logic hold;

   always_ff @(posedge clock) begin
      if (reset) mod_ff <= mau_pkg::ModulusReset;
      else if (csr_write) mod_ff <= csr_wdata;
   end

   // A new item is taken whenever the controller idles.
   assign req.ready = !busy;
   assign start = req.valid && req.ready;
   // The result register is busy until its item is taken.
   assign hold = rv_ff && !rsp.ready;

   mau_ctrl #(.OPERAND_BITS(OPERAND_BITS)) u_ctrl (
      .clock, .reset, .start, .command(req.command),
      .p_small(mod_ff < 31'd2), .hold, .stat, .cmd, .busy, .done, .err, .zero
   );

   mau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
      .clock, .load(start), .a_in(req.operand_a), .b_in(req.operand_b),
      .p(mod_ff), .cmd, .stat, .acc
   );

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (done) rv_ff <= 1'b1;
      else if (rsp.ready) rv_ff <= 1'b0;
      if (done) begin
         er_ff <= err;
         res_ff <= zero ? 31'd0 : acc;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.result = res_ff;
   assign rsp.error = er_ff;

   `MAU_ASSERT_IMPL(a_no_accept_busy, clock, reset, start |=> busy)
   `MAU_ASSERT_IMPL(a_err_zero, clock, reset, (rsp.valid && rsp.error) |-> (rsp.result == 31'd0))
   `MAU_ASSERT_IMPL(a_done_valid, clock, reset, done |=> rsp.valid)
   `MAU_ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.result)))
endmodule

### sv/mau_datapath.sv
// Datapath: operand reducers, exponent register and two interleaved modular multipliers.
module mau_datapath #(
   parameter int OPERAND_BITS = 63
) (
   input  logic                      clock,
   input  logic                      load,
   input  logic [OPERAND_BITS-1:0]   a_in,
   input  logic [OPERAND_BITS-1:0]   b_in,
   input  logic [30:0]               p,
   input  mau_pkg::dp_cmd_type       cmd,
   output mau_pkg::dp_stat_type      stat,
   output logic [30:0]               acc
);
   logic [OPERAND_BITS-1:0] sa_ff, sa_in, sb_ff, sb_in, e_ff, e_in;
   logic [30:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [30:0] x_ff, x_in, acc_ff, acc_in, n_ff, n_in;
   logic [30:0] rs_ff, rs_in, rm_ff, rm_in;

   // One restoring reduction bit: shift in the next operand bit, subtract m when it fits.
   function automatic logic [30:0] reduce_bit(input logic [30:0] r, input logic bitin,
                                              input logic [30:0] m);
      logic [31:0] s;
      s = {r, bitin};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[30:0];
   endfunction

   // One multiplier bit, most significant first: r := 2r + bitin*m mod q, r and m below q.
   function automatic logic [30:0] mul_bit(input logic [30:0] r, input logic bitin,
                                           input logic [30:0] m, input logic [30:0] q);
      logic [31:0] d;
      logic [31:0] s;
      d = {r, 1'b0};
      if (d >= {1'b0, q}) d = d - {1'b0, q};
      s = d + (bitin ? {1'b0, m} : 32'd0);
      if (s >= {1'b0, q}) s = s - {1'b0, q};
      return s[30:0];
   endfunction

   always_comb begin
      sa_in = sa_ff; sb_in = sb_ff; e_in = e_ff;
      ra_in = ra_ff; rb_in = rb_ff;
      x_in = x_ff; acc_in = acc_ff; n_in = n_ff;
      rs_in = rs_ff; rm_in = rm_ff;
      if (load) begin
         sa_in = a_in; sb_in = b_in; e_in = b_in;
         ra_in = '0; rb_in = '0;
      end
      if (cmd.red_step) begin
         ra_in = reduce_bit(ra_ff, sa_ff[OPERAND_BITS-1], p);
         rb_in = reduce_bit(rb_ff, sb_ff[OPERAND_BITS-1], p);
         sa_in = {sa_ff[OPERAND_BITS-2:0], 1'b0};
         sb_in = {sb_ff[OPERAND_BITS-2:0], 1'b0};
      end
      if (cmd.load_pow) begin
         x_in = ra_ff; acc_in = 31'd1;
      end
      if (cmd.load_inv) begin
         x_in = rb_ff; acc_in = 31'd1;
         e_in = OPERAND_BITS'(p - 31'd2);
      end
      if (cmd.load_mul) begin
         x_in = rb_ff; acc_in = ra_ff;
      end
      if (cmd.load_fin) x_in = ra_ff;
      if (cmd.pass_start) begin
         rs_in = '0; rm_in = '0; n_in = x_ff;
      end
      if (cmd.pass_step) begin
         // The square and the product share the multiplier bits of x.
         rs_in = mul_bit(rs_ff, n_ff[30], x_ff, p);
         rm_in = mul_bit(rm_ff, n_ff[30], acc_ff, p);
         n_in = {n_ff[29:0], 1'b0};
      end
      if (cmd.pow_end) begin
         x_in = rs_ff;
         if (e_ff[0]) acc_in = rm_ff;
         e_in = e_ff >> 1;
      end
      if (cmd.mul_end) acc_in = rm_ff;
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in; sb_ff <= sb_in; e_ff <= e_in;
      ra_ff <= ra_in; rb_ff <= rb_in;
      x_ff <= x_in; acc_ff <= acc_in; n_ff <= n_in;
      rs_ff <= rs_in; rm_ff <= rm_in;
   end

   assign stat.e_zero = (e_ff == '0);
   assign stat.b_zero = (rb_ff == 31'd0);
   assign acc = acc_ff;
endmodule

### sv/mau_ctrl.sv
// Controller state machine sequencing the datapath for one item.
module mau_ctrl #(
   parameter int OPERAND_BITS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            command,
   input  logic                  p_small,
   input  logic                  hold,
   input  mau_pkg::dp_stat_type  stat,
   output mau_pkg::dp_cmd_type   cmd,
   output logic                  busy,
   output logic                  done,
   output logic                  err,
   output logic                  zero
);
   localparam int CntBits = $clog2(OPERAND_BITS + 1);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RED   = 7'b0000010,
      S_PCHK  = 7'b0000100,
      S_PPASS = 7'b0001000,
      S_MINIT = 7'b0010000,
      S_MPASS = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;
   state_type st_ff, st_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   mau_pkg::cmd_type c_ff, c_in;
   logic err_ff, err_in, zero_ff, zero_in;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; c_in = c_ff;
      err_in = err_ff; zero_in = zero_ff;
      cmd = '0;
      done = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               c_in = mau_pkg::cmd_type'(command);
               err_in = p_small && command == mau_pkg::CMD_DIV;
               zero_in = p_small || command == mau_pkg::CMD_NONE;
               if (p_small || command == mau_pkg::CMD_NONE) begin
                  st_in = S_DONE;
               end else begin
                  cnt_in = CntBits'(OPERAND_BITS); st_in = S_RED;
               end
            end
         end
         S_RED: begin
            // Both operands are reduced together, one bit per cycle.
            if (cnt_ff != '0) begin
               cmd.red_step = 1'b1; cnt_in = cnt_ff - CntBits'(1);
            end else begin
               case (c_ff)
                  mau_pkg::CMD_POW: begin
                     cmd.load_pow = 1'b1; st_in = S_PCHK;
                  end
                  mau_pkg::CMD_MUL: begin
                     cmd.load_mul = 1'b1; st_in = S_MINIT;
                  end
                  mau_pkg::CMD_DIV: begin
                     if (stat.b_zero) begin
                        err_in = 1'b1; zero_in = 1'b1; st_in = S_DONE;
                     end else begin
                        cmd.load_inv = 1'b1; st_in = S_PCHK;
                     end
                  end
                  default: st_in = S_DONE;
               endcase
            end
         end
         S_PCHK: begin
            // Power and the inverse stop once no exponent bits are left; divide then multiplies by a.
            if (!stat.e_zero) begin
               cmd.pass_start = 1'b1; cnt_in = CntBits'(mau_pkg::PassSteps);
               st_in = S_PPASS;
            end else if (c_ff == mau_pkg::CMD_DIV) begin
               cmd.load_fin = 1'b1; st_in = S_MINIT;
            end else begin
               st_in = S_DONE;
            end
         end
         S_PPASS: begin
            if (cnt_ff != '0) begin
               cmd.pass_step = 1'b1; cnt_in = cnt_ff - CntBits'(1);
            end else begin
               cmd.pow_end = 1'b1; st_in = S_PCHK;
            end
         end
         S_MINIT: begin
            cmd.pass_start = 1'b1; cnt_in = CntBits'(mau_pkg::PassSteps);
            st_in = S_MPASS;
         end
         S_MPASS: begin
            if (cnt_ff != '0) begin
               cmd.pass_step = 1'b1; cnt_in = cnt_ff - CntBits'(1);
            end else begin
               cmd.mul_end = 1'b1; st_in = S_DONE;
            end
         end
         S_DONE: begin
            // Wait while the result register still holds an untaken item.
            if (!hold) begin
               done = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
      cnt_ff <= cnt_in; c_ff <= c_in; err_ff <= err_in; zero_ff <= zero_in;
   end

   assign busy = (st_ff != S_IDLE);
   assign err = err_ff;
   assign zero = zero_ff;
endmodule
